// File: sv/padp_pkg.sv
// Shared types and constants of the ping-pong audio DAC player.
// No dependencies; every other file of the block but padp_ram imports this package.
`timescale 1ns / 1ps
`default_nettype none
package padp_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CODE_W   = 12;
   localparam int COUNT_W  = 12;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_PLAY_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_LEVEL    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_OFFSET = 2'd2;

   localparam logic [COUNT_W-1:0]  PLAY_COUNT_RST    = 12'd434;
   localparam logic [CODE_W-1:0]   IDLE_LEVEL_RST    = 12'd2048;
   localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET_RST = 16'd32675;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef struct packed {
      logic [COUNT_W-1:0]  play_count;
      logic [CODE_W-1:0]   idle_level;
      logic [SAMPLE_W-1:0] sample_offset;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic idle;
   } rd_stage_type;

endpackage
`default_nettype wire

// File: sv/padp_req_if.sv
// Input channel of the player: write or tick beats with valid/ready.
// Depends on padp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface padp_req_if;
   import padp_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       opcode;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       last_of_packet;

   modport source (output valid, output opcode, output sample, output last_of_packet,
                   input ready);
   modport sink   (input valid, input opcode, input sample, input last_of_packet,
                   output ready);
endinterface
`default_nettype wire

// File: sv/padp_rsp_if.sv
// Result channel of the player: one DAC code beat per tick.
// Depends on padp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface padp_rsp_if;
   import padp_pkg::*;

   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] dac_code;
   logic              idle;

   modport source (output valid, output dac_code, output idle, input ready);
   modport sink   (input valid, input dac_code, input idle, output ready);
endinterface
`default_nettype wire

// File: sv/pingpong_audio_dac_player.sv
// Top level of the ping-pong audio DAC player: configuration registers,
// bank control with sample RAM, and the scaling/result stage.
//
//   port group   dir    beat contents
//   req          sink   opcode, sample, last_of_packet
//   rsp          source dac_code, idle (one beat per tick)
//   csr_*        APB    play_count @0x0, idle_level @0x4, sample_offset @0x8
//
// One beat accepted per cycle while req.ready is high; a tick's code passes the
// RAM read register, then the result register, before it appears on rsp.
// After reset the sample RAM is cleared one entry a cycle, all 2*BANK_DEPTH
// entries (4096 at the default), with req.ready low. A stalled result holds;
// after clearing, req.ready drops only while a tick waits behind it.
`timescale 1ns / 1ps
`default_nettype none
module pingpong_audio_dac_player #(
   parameter int BANK_DEPTH = 2048
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   padp_req_if.sink                               req,
   padp_rsp_if.source                             rsp,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [padp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [padp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [padp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready
);
   import padp_pkg::*;

   cfg_type             cfg;
   rd_stage_type        rd_stage;
   logic [SAMPLE_W-1:0] rd_data;
   logic                take_rd;

   padp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   padp_ctrl #(
      .BANK_DEPTH (BANK_DEPTH)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .cfg      (cfg),
      .take_rd  (take_rd),
      .rd_stage (rd_stage),
      .rd_data  (rd_data)
   );

   padp_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .rd_stage (rd_stage),
      .rd_data  (rd_data),
      .take_rd  (take_rd),
      .rsp      (rsp)
   );
endmodule
`default_nettype wire

// File: sv/padp_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module padp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// File: sv/padp_csr.sv
// APB-style configuration registers: play count, idle level, sample offset.
// Depends on padp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module padp_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [padp_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [padp_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [padp_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                   csr_pready,
   output padp_pkg::cfg_type                      cfg
);
   import padp_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic [CSR_IDX_W-1:0] idx;
   logic                 wr_go;

   assign idx   = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_go = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_go) begin
         case (idx)
            REG_PLAY_COUNT:    cfg_in.play_count    = csr_pwdata[COUNT_W-1:0];
            REG_IDLE_LEVEL:    cfg_in.idle_level    = csr_pwdata[CODE_W-1:0];
            REG_SAMPLE_OFFSET: cfg_in.sample_offset = csr_pwdata[SAMPLE_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.play_count    <= PLAY_COUNT_RST;
         cfg_ff.idle_level    <= IDLE_LEVEL_RST;
         cfg_ff.sample_offset <= SAMPLE_OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_PLAY_COUNT:    csr_prdata = CSR_DATA_W'(cfg_ff.play_count);
         REG_IDLE_LEVEL:    csr_prdata = CSR_DATA_W'(cfg_ff.idle_level);
         REG_SAMPLE_OFFSET: csr_prdata = CSR_DATA_W'(cfg_ff.sample_offset);
         default:           csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;
endmodule
`default_nettype wire

// File: sv/padp_ctrl.sv
// Bank control: write and read indexes, bank swap, overflow, clearing pass,
// and the two-bank sample RAM. Depends on padp_pkg, padp_req_if and padp_ram.
`timescale 1ns / 1ps
`default_nettype none
module padp_ctrl #(
   parameter int BANK_DEPTH = 2048
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   padp_req_if.sink                            req,
   input  wire padp_pkg::cfg_type              cfg,
   input  wire logic                           take_rd,
   output padp_pkg::rd_stage_type              rd_stage,
   output logic [padp_pkg::SAMPLE_W-1:0]       rd_data
);
   import padp_pkg::*;

   localparam int RAM_DEPTH = 2 * BANK_DEPTH;
   localparam int AW        = $clog2(RAM_DEPTH);
   localparam int IDX_W     = $clog2(BANK_DEPTH + 1);
   localparam int CMP_W     = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;

   logic               clear_ff, clear_in;
   logic [AW-1:0]      clr_addr_ff, clr_addr_in;
   logic [IDX_W-1:0]   windex_ff, windex_in;
   logic [IDX_W-1:0]   rindex_ff, rindex_in;
   logic               bank_ff, bank_in;
   logic               wovf_ff, wovf_in;
   logic               exh_ff, exh_in;
   rd_stage_type       rd_ff, rd_in;

   logic               accept, write_go, tick_go, store, swap, tick_idle;
   logic [AW-1:0]      wr_addr, rd_addr, ram_wr_addr;
   logic [SAMPLE_W-1:0] ram_wr_data;
   logic               ram_wr_en;

   assign req.ready = !clear_ff && (!rd_ff.valid || take_rd);
   assign accept    = req.valid && req.ready;
   assign write_go  = accept && (req.opcode == OP_WRITE);
   assign tick_go   = accept && (req.opcode == OP_TICK);

   assign store = !wovf_ff && (windex_ff < IDX_W'(BANK_DEPTH));
   assign swap  = write_go && req.last_of_packet && store;

   assign tick_idle = exh_ff
                   || (CMP_W'(rindex_ff) >= CMP_W'(cfg.play_count))
                   || (rindex_ff >= IDX_W'(BANK_DEPTH));

   assign wr_addr = bank_ff ? AW'(windex_ff) : AW'(windex_ff) + AW'(BANK_DEPTH);
   assign rd_addr = bank_ff ? AW'(rindex_ff) + AW'(BANK_DEPTH) : AW'(rindex_ff);

   always_comb begin
      clear_in    = clear_ff;
      clr_addr_in = clr_addr_ff;
      windex_in   = windex_ff;
      rindex_in   = rindex_ff;
      bank_in     = bank_ff;
      wovf_in     = wovf_ff;
      exh_in      = exh_ff;
      rd_in       = rd_ff;

      if (clear_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == AW'(RAM_DEPTH - 1)) begin
            clear_in = 1'b0;
         end
      end

      if (write_go) begin
         if (req.last_of_packet) begin
            windex_in = '0;
            wovf_in   = 1'b0;
         end else if (store) begin
            windex_in = windex_ff + 1'b1;
         end else begin
            wovf_in = 1'b1;
         end
      end

      if (swap) begin
         bank_in   = !bank_ff;
         rindex_in = '0;
         exh_in    = 1'b0;
      end

      if (tick_go) begin
         rd_in.valid = 1'b1;
         rd_in.idle  = tick_idle;
         if (!tick_idle) begin
            rindex_in = rindex_ff + 1'b1;
         end
      end else if (take_rd) begin
         rd_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
         windex_ff   <= '0;
         rindex_ff   <= '0;
         bank_ff     <= 1'b0;
         wovf_ff     <= 1'b0;
         exh_ff      <= 1'b1;
         rd_ff       <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
         windex_ff   <= windex_in;
         rindex_ff   <= rindex_in;
         bank_ff     <= bank_in;
         wovf_ff     <= wovf_in;
         exh_ff      <= exh_in;
         rd_ff       <= rd_in;
      end
   end

   assign ram_wr_en   = clear_ff || (write_go && store);
   assign ram_wr_addr = clear_ff ? clr_addr_ff : wr_addr;
   assign ram_wr_data = clear_ff ? '0 : SAMPLE_W'(req.sample);

   padp_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (tick_go),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_stage = rd_ff;

`ifndef SYNTH
   a_windex_bound: assert property (@(posedge clock) disable iff (reset)
      windex_ff <= IDX_W'(BANK_DEPTH))
      else $error("write index beyond bank");

   a_tick_advance: assert property (@(posedge clock) disable iff (reset)
      tick_go && !tick_idle |=> rindex_ff == $past(rindex_ff) + 1'b1)
      else $error("read index did not advance on a played beat");

   a_swap: assert property (@(posedge clock) disable iff (reset)
      swap |=> rindex_ff == '0 && !exh_ff && bank_ff != $past(bank_ff))
      else $error("bank swap incomplete");

   a_exh_idle: assert property (@(posedge clock) disable iff (reset)
      tick_go && exh_ff |=> rd_ff.valid && rd_ff.idle)
      else $error("exhausted bank played a sample");
`endif
endmodule
`default_nettype wire

// File: sv/padp_scale.sv
// Offset, scaling to a 12-bit DAC code and the result register.
// Depends on padp_pkg and padp_rsp_if.
`timescale 1ns / 1ps
`default_nettype none
module padp_scale (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire padp_pkg::cfg_type          cfg,
   input  wire padp_pkg::rd_stage_type     rd_stage,
   input  wire logic [padp_pkg::SAMPLE_W-1:0] rd_data,
   output logic                            take_rd,
   padp_rsp_if.source                      rsp
);
   import padp_pkg::*;

   logic                out_valid_ff, out_valid_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic                idle_ff, idle_in;

   logic [SAMPLE_W-1:0] u;
   logic [27:0]         x, x_sum, q_mul, r_full;
   logic [CODE_W-1:0]   q0, code;
   logic [16:0]         r0;

   // code = floor(u * 4095 / 65535); estimate is low by at most one
   assign u      = rd_data + cfg.sample_offset;
   assign x      = {u, 12'd0} - 28'(u);
   assign x_sum  = x + 28'(x[27:16]);
   assign q0     = x_sum[27:16];
   assign q_mul  = {q0, 16'd0} - 28'(q0);
   assign r_full = x - q_mul;
   assign r0     = r_full[16:0];
   assign code   = (r0 >= 17'd65535) ? q0 + 1'b1 : q0;

   assign take_rd = !out_valid_ff || rsp.ready;

   always_comb begin
      out_valid_in = out_valid_ff;
      code_in      = code_ff;
      idle_in      = idle_ff;
      if (take_rd) begin
         out_valid_in = rd_stage.valid;
         idle_in      = rd_stage.idle;
         code_in      = rd_stage.idle ? cfg.idle_level : code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      code_ff <= code_in;
      idle_ff <= idle_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.dac_code = code_ff;
   assign rsp.idle     = idle_ff;
endmodule
`default_nettype wire
